// ===== src/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  localparam int unsigned HALF_W  = 16;
  localparam int unsigned RETRY_W = 5;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [HALF_W-1:0] HALF_RESET = 16'd100;

  // sequencer -> hold timer
  typedef struct packed {
    logic advance;  // tick word accepted
    logic restart;  // a new step is entered on this tick
    logic quarter;  // current step is a NACK retry wait
  } tctl_t;

  // one result word
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       oe;
    logic       busy;
    logic       done;
    logic       ack;
    logic [7:0] rd_data;
  } res_t;

endpackage

`default_nettype wire

// ===== src/i2cm_timer.sv =====
// ----------------------------------------------------------------------------
// i2cm_timer
// Step hold counter: flags the tick on which the current bus step ends.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_timer #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [i2cm_pkg::HALF_W-1:0] half_period_ticks,
  input  wire i2cm_pkg::tctl_t             ctl,
  output logic                             step_end
);

  import i2cm_pkg::*;

  logic [DELAY_WIDTH-1:0] tick_count;
  logic [DELAY_WIDTH-1:0] half;
  logic [DELAY_WIDTH-1:0] dur;

  always_comb begin
    half = DELAY_WIDTH'(half_period_ticks);
    if (half == '0) begin
      half = DELAY_WIDTH'(1);
    end
    dur = ctl.quarter ? (half >> 2) : half;
    if (dur == '0) begin
      dur = DELAY_WIDTH'(1);
    end
    step_end = !(tick_count < dur);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (ctl.advance) begin
      if (ctl.restart) begin
        tick_count <= DELAY_WIDTH'(1);
      end else if (!step_end) begin
        tick_count <= tick_count + DELAY_WIDTH'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/i2cm_seq.sv =====
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus step sequencer: command decode, bit shifting, acknowledge retries and
// pin registers. Its registers form the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_seq #(
  parameter int unsigned ACK_RETRIES = 20
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic             cmd_valid,
  input  wire logic [1:0]       kind,
  input  wire logic [7:0]       wr_data,
  input  wire logic             send_ack,
  input  wire logic             sda_in,
  input  wire logic             step_end,
  output i2cm_pkg::tctl_t       tctl,
  output i2cm_pkg::res_t        res
);

  import i2cm_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_S0, PH_S1, PH_S2, PH_P0, PH_P1, PH_P2,
    PH_WBIT, PH_WHI, PH_WLO, PH_AREL, PH_APOST, PH_ARETRY, PH_ACLK, PH_AREL2,
    PH_RREL, PH_RHI, PH_RLO, PH_RACK, PH_RAHI, PH_RALO, PH_REND
  } phase_t;

  phase_t             phase, phase_next, tgt;
  logic               enter_en;
  logic [2:0]         bit_index, bit_index_next;
  logic [7:0]         shift_reg, shift_reg_next;
  logic [RETRY_W-1:0] ack_retry, ack_retry_next;
  logic               ack_flag, ack_flag_next;
  logic               ack_to_send, ack_to_send_next;
  logic [7:0]         rx_byte, rx_byte_next;
  logic               scl, scl_next;
  logic               sda, sda_next;
  logic               oe, oe_next;
  logic               done, done_next;

  always_comb begin
    phase_next       = phase;
    tgt              = phase;
    enter_en         = 1'b0;
    bit_index_next   = bit_index;
    shift_reg_next   = shift_reg;
    ack_retry_next   = ack_retry;
    ack_flag_next    = ack_flag;
    ack_to_send_next = ack_to_send;
    rx_byte_next     = rx_byte;
    scl_next         = scl;
    sda_next         = sda;
    oe_next          = oe;
    done_next        = 1'b0;

    if (phase == PH_IDLE) begin
      if (cmd_valid) begin
        enter_en       = 1'b1;
        bit_index_next = '0;
        unique case (kind)
          CMD_START: tgt = PH_S0;
          CMD_STOP:  tgt = PH_P0;
          CMD_WRITE: begin
            shift_reg_next = wr_data;
            tgt            = PH_WBIT;
          end
          default: begin
            ack_to_send_next = send_ack;
            shift_reg_next   = '0;
            tgt              = PH_RREL;
          end
        endcase
      end
    end else if (step_end) begin
      enter_en = 1'b1;
      unique case (phase)
        PH_S0:    tgt = PH_S1;
        PH_S1:    tgt = PH_S2;
        PH_P0:    tgt = PH_P1;
        PH_P1:    tgt = PH_P2;
        PH_WBIT:  tgt = PH_WHI;
        PH_WHI:   tgt = PH_WLO;
        PH_WLO: begin
          shift_reg_next = {shift_reg[6:0], 1'b0};
          bit_index_next = bit_index + 3'd1;
          tgt = (bit_index == 3'd7) ? PH_AREL : PH_WBIT;
        end
        PH_AREL: begin
          ack_flag_next = !sda_in;
          tgt           = PH_APOST;
        end
        PH_APOST: begin
          ack_retry_next = '0;
          tgt = ack_flag ? PH_ACLK : PH_ARETRY;
        end
        PH_ARETRY: begin
          if (ack_retry >= RETRY_W'(ACK_RETRIES)) begin
            tgt = PH_ACLK;
          end else begin
            ack_retry_next = ack_retry + RETRY_W'(1);
            ack_flag_next  = !sda_in;
            tgt = sda_in ? PH_ARETRY : PH_ACLK;
          end
        end
        PH_ACLK:  tgt = PH_AREL2;
        PH_RREL:  tgt = PH_RHI;
        PH_RHI: begin
          shift_reg_next = {shift_reg[6:0], sda_in};
          tgt            = PH_RLO;
        end
        PH_RLO: begin
          bit_index_next = bit_index + 3'd1;
          tgt = (bit_index == 3'd7) ? PH_RACK : PH_RHI;
        end
        PH_RACK:  tgt = PH_RAHI;
        PH_RAHI:  tgt = PH_RALO;
        PH_RALO:  tgt = PH_REND;
        PH_REND: begin
          rx_byte_next = shift_reg;
          enter_en     = 1'b0;
          done_next    = 1'b1;
          phase_next   = PH_IDLE;
        end
        default: begin
          // last step of start, stop and write
          enter_en   = 1'b0;
          done_next  = 1'b1;
          phase_next = PH_IDLE;
        end
      endcase
    end

    if (enter_en) begin
      phase_next = tgt;
      unique case (tgt)
        PH_S0: begin
          scl_next = 1'b1;
          sda_next = 1'b1;
          oe_next  = 1'b1;
        end
        PH_S1, PH_P0: begin
          sda_next = 1'b0;
          oe_next  = 1'b1;
        end
        PH_P2, PH_AREL2, PH_REND: begin
          sda_next = 1'b1;
          oe_next  = 1'b1;
        end
        PH_WBIT: begin
          sda_next = shift_reg_next[7];
          oe_next  = 1'b1;
        end
        PH_RACK: begin
          sda_next = !ack_to_send_next;
          oe_next  = 1'b1;
        end
        PH_AREL: begin
          scl_next = 1'b1;
          sda_next = 1'b1;
          oe_next  = 1'b0;
        end
        PH_RREL: begin
          sda_next = 1'b1;
          oe_next  = 1'b0;
        end
        PH_P1, PH_WHI, PH_RHI, PH_RAHI: scl_next = 1'b1;
        PH_S2, PH_WLO, PH_ACLK, PH_RLO, PH_RALO: scl_next = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_index   <= '0;
      shift_reg   <= '0;
      ack_retry   <= '0;
      ack_flag    <= 1'b0;
      ack_to_send <= 1'b0;
      rx_byte     <= '0;
      scl         <= 1'b1;
      sda         <= 1'b1;
      oe          <= 1'b1;
      done        <= 1'b0;
    end else if (advance) begin
      phase       <= phase_next;
      bit_index   <= bit_index_next;
      shift_reg   <= shift_reg_next;
      ack_retry   <= ack_retry_next;
      ack_flag    <= ack_flag_next;
      ack_to_send <= ack_to_send_next;
      rx_byte     <= rx_byte_next;
      scl         <= scl_next;
      sda         <= sda_next;
      oe          <= oe_next;
      done        <= done_next;
    end
  end

  always_comb begin
    tctl.advance = advance;
    tctl.restart = enter_en;
    tctl.quarter = (phase == PH_ARETRY);

    res.scl     = scl;
    res.sda     = sda;
    res.oe      = oe;
    res.busy    = (phase != PH_IDLE);
    res.done    = done;
    res.ack     = ack_flag;
    res.rd_data = rx_byte;
  end

endmodule

`default_nettype wire

// ===== src/i2c_master_byte_engine.sv =====
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master pin sequencer, advanced by one input word per bus tick.
// ----------------------------------------------------------------------------
// Each input word is one bus tick with the sampled SDA level; when the engine
// is idle a word with cmd_valid set starts start, stop, write or read.
// Every input word yields exactly one result word with the pin levels, busy,
// done, acknowledge status and last received byte after that tick.
// Both channels are valid/ready. An accepted word shows its result in the next
// cycle on the output register; one word per cycle is sustained while the
// output side takes words. The engine state doubles as the output register,
// so in_ready = !out_valid || out_ready: a stalled output holds the result
// and blocks input until taken.
// Each bus step lasts half_period_ticks ticks (a NACK retry wait a quarter
// of that, at least one tick), set through cfg_we/cfg_wdata by the user only
// while idle, which the engine does not enforce. Reset (sync, rst) leaves SCL
// high, SDA driven high, half_period_ticks = 100, no command, out_valid low.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine #(
  parameter int unsigned ACK_RETRIES = 20,
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [i2cm_pkg::HALF_W-1:0] cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        cmd_valid,
  input  wire logic [1:0]                  kind,
  input  wire logic [7:0]                  wr_data,
  input  wire logic                        send_ack,
  input  wire logic                        sda_in,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             scl_out,
  output logic                             sda_out,
  output logic                             sda_oe,
  output logic                             busy_res,
  output logic                             done_res,
  output logic                             ack_ok,
  output logic [7:0]                       rd_data
);

  import i2cm_pkg::*;

  logic [HALF_W-1:0] half_period_ticks;
  logic              accept;
  logic              step_end;
  tctl_t             tctl;
  res_t              res;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_RESET;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        half_period_ticks <= cfg_wdata;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  i2cm_timer #(
    .DELAY_WIDTH(DELAY_WIDTH)
  ) u_timer (
    .clk              (clk),
    .rst              (rst),
    .half_period_ticks(half_period_ticks),
    .ctl              (tctl),
    .step_end         (step_end)
  );

  i2cm_seq #(
    .ACK_RETRIES(ACK_RETRIES)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .advance  (accept),
    .cmd_valid(cmd_valid),
    .kind     (kind),
    .wr_data  (wr_data),
    .send_ack (send_ack),
    .sda_in   (sda_in),
    .step_end (step_end),
    .tctl     (tctl),
    .res      (res)
  );

  assign scl_out  = res.scl;
  assign sda_out  = res.sda;
  assign sda_oe   = res.oe;
  assign busy_res = res.busy;
  assign done_res = res.done;
  assign ack_ok   = res.ack;
  assign rd_data  = res.rd_data;

`ifndef NO_ASSERTIONS
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> !busy_res)
    else $error("done word still reports busy");

  a_release_high: assert property (@(posedge clk) disable iff (rst)
    !sda_oe |-> sda_out)
    else $error("released SDA not reading high");

  a_accept_gives_word: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(res) && !$past(accept)))
    else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire
